// File: rtl/core/lxc_pkg.sv
// Shared types, constants and character predicates of the lexical token classifier.
// Used by lxc_scan, lxc_out_fifo and lexical_token_classifier; depends on nothing.
`default_nettype none
package lxc_pkg;

  localparam int MAX_TOKEN_LEN = 64;
  localparam int LEN_W         = 7;
  localparam int LEN_CAP       = (MAX_TOKEN_LEN < 127) ? MAX_TOKEN_LEN : 127;
  localparam int HEAD_CHARS    = 8;
  localparam int HEAD_W        = 8 * HEAD_CHARS;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [HEAD_W-1:0] WORD_MAIN = 64'h0000_0000_6E69_616D;
  localparam logic [HEAD_W-1:0] WORD_VOID = 64'h0000_0000_6469_6F76;
  localparam logic [LEN_W-1:0]  KEYWORD_LEN = 7'd4;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NUM,
    SCAN_IDENT,
    SCAN_OPER
  } scan_state_t;

  typedef enum logic [2:0] {
    CLS_NUM   = 3'd0,
    CLS_IDENT = 3'd1,
    CLS_KEY   = 3'd2,
    CLS_OPER  = 3'd3,
    CLS_SYM   = 3'd4
  } tok_class_t;

  typedef struct packed {
    tok_class_t        cls;
    logic [LEN_W-1:0]  len;
    logic [HEAD_W-1:0] head;
    logic              last;
  } token_t;

  // Tokens produced by one character, first in order of delivery.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } token_pair_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == 8'h5F);
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return (c == 8'h2A) || (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2F);
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return (c == 8'h7B) || (c == 8'h7D) || (c == 8'h28) || (c == 8'h29) ||
           (c == 8'h3B) || (c == 8'h2C);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/lxc_scan.sv
// Scanner of the lexical token classifier: scan state, open token length and head.
// Depends on lxc_pkg.
`default_nettype none
module lxc_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         char_code,
  output lxc_pkg::token_pair_t tokens
);
  import lxc_pkg::*;

  scan_state_t       scan_state, scan_state_next;
  logic [LEN_W-1:0]  token_len, token_len_next;
  logic [HEAD_W-1:0] token_head, token_head_next;

  logic              cont;
  logic              ends;
  logic              sym;
  scan_state_t       start_state;
  logic [HEAD_W-1:0] head_add;
  token_t            end_tok;
  token_t            sym_tok;

  always_comb begin
    unique case (scan_state)
      SCAN_NUM:   cont = is_digit(char_code);
      SCAN_IDENT: cont = is_digit(char_code) || is_alpha(char_code);
      SCAN_OPER:  cont = is_oper(char_code);
      default:    cont = 1'b0;
    endcase
    ends = (scan_state != SCAN_IDLE) && !cont;
    sym  = is_sym(char_code);

    priority if (is_digit(char_code)) start_state = SCAN_NUM;
    else if (is_alpha(char_code))     start_state = SCAN_IDENT;
    else if (is_oper(char_code))      start_state = SCAN_OPER;
    else                              start_state = SCAN_IDLE;

    // Byte lane the character lands in while the head still has room.
    for (int b = 0; b < HEAD_CHARS; b++) begin
      head_add[b*8 +: 8] = (token_len < LEN_W'(HEAD_CHARS)) &&
                           (token_len[2:0] == 3'(b)) ? char_code : 8'h00;
    end
  end

  // Next state.
  always_comb begin
    if ((scan_state != SCAN_IDLE) && cont) begin
      scan_state_next = scan_state;
      token_head_next = token_head | head_add;
      token_len_next  = (token_len < LEN_W'(LEN_CAP)) ? token_len + 1'b1 : token_len;
    end else if (start_state != SCAN_IDLE) begin
      scan_state_next = start_state;
      token_head_next = {{(HEAD_W-8){1'b0}}, char_code};
      token_len_next  = LEN_W'(1);
    end else begin
      scan_state_next = SCAN_IDLE;
      token_head_next = '0;
      token_len_next  = '0;
    end
  end

  // Outputs.
  always_comb begin
    end_tok.len  = token_len;
    end_tok.head = token_head;
    end_tok.last = !sym;
    unique case (scan_state)
      SCAN_NUM:   end_tok.cls = CLS_NUM;
      SCAN_IDENT: end_tok.cls = ((token_len == KEYWORD_LEN) &&
                                 ((token_head == WORD_MAIN) || (token_head == WORD_VOID)))
                                ? CLS_KEY : CLS_IDENT;
      default:    end_tok.cls = CLS_OPER;
    endcase

    sym_tok.cls  = CLS_SYM;
    sym_tok.len  = LEN_W'(1);
    sym_tok.head = {{(HEAD_W-8){1'b0}}, char_code};
    sym_tok.last = 1'b1;

    tokens.count  = {1'b0, ends} + {1'b0, sym};
    tokens.first  = ends ? end_tok : sym_tok;
    tokens.second = sym_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= SCAN_IDLE;
      token_len  <= '0;
      token_head <= '0;
    end else if (accept) begin
      scan_state <= scan_state_next;
      token_len  <= token_len_next;
      token_head <= token_head_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/lxc_out_fifo.sv
// Result buffer of the lexical token classifier: takes up to two tokens a cycle
// and delivers one a cycle when popped. Depends on lxc_pkg.
`default_nettype none
module lxc_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lxc_pkg::token_pair_t tokens,
  input  logic                 pop,
  output logic                 room,
  output logic                 valid,
  output lxc_pkg::token_t      head_tok,
  output logic [lxc_pkg::FIFO_CNT_W-1:0] fill
);
  import lxc_pkg::*;

  token_t                entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] rd_ptr, wr_ptr;
  logic [FIFO_CNT_W-1:0] count, count_next;
  logic [1:0]            n_push;

  assign n_push   = push ? tokens.count : 2'd0;
  assign valid    = (count != '0);
  assign room     = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign head_tok = entries[rd_ptr];
  assign fill     = count;

  always_comb begin
    count_next = count + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) entries[wr_ptr] <= tokens.first;
    if (n_push == 2'd2) entries[wr_ptr + 1'b1] <= tokens.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      wr_ptr <= wr_ptr + FIFO_PTR_W'(n_push);
      count  <= count_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/lexical_token_classifier.sv
// Top level of the lexical token classifier: scanner plus result buffer.
// Depends on lxc_pkg, lxc_scan and lxc_out_fifo.
`default_nettype none
// The classifier takes one source byte per transaction on the char channel and
// emits token transactions on the token channel. It accepts one byte every
// clock cycle as long as the token channel keeps up. A byte that closes an open
// token and is itself a bracket, semicolon or comma yields two tokens; since the
// token channel moves at most one token per cycle, such bytes take more output
// bandwidth, and the char channel stalls whenever the four-entry result buffer
// has fewer than two free slots. A token is buffered when its closing byte is
// accepted, behind tokens already there. last_of_run marks the final token of a
// byte. A token still open when the stream stops is held, not emitted.
module lexical_token_classifier (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        char_valid,
  output logic                        char_stall,
  input  logic [7:0]                  char_code,
  output logic                        token_valid,
  input  logic                        token_stall,
  output logic [2:0]                  token_class,
  output logic [lxc_pkg::LEN_W-1:0]   token_length,
  output logic [lxc_pkg::HEAD_W-1:0]  token_head,
  output logic                        last_of_run
);
  import lxc_pkg::*;

  logic                  accept;
  logic                  pop;
  logic                  room;
  token_pair_t           tokens;
  token_t                head_tok;
  logic [FIFO_CNT_W-1:0] fill;

  // The char channel only waits on buffer space, never on the byte itself.
  assign char_stall = !room;
  assign accept     = char_valid && room;
  assign pop        = token_valid && !token_stall;

  lxc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .tokens    (tokens)
  );

  lxc_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .tokens   (tokens),
    .pop      (pop),
    .room     (room),
    .valid    (token_valid),
    .head_tok (head_tok),
    .fill     (fill)
  );

  assign token_class  = head_tok.cls;
  assign token_length = head_tok.len;
  assign token_head   = head_tok.head;
  assign last_of_run  = head_tok.last;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result buffer overfilled");

  a_sym_len: assert property (@(posedge clk) disable iff (rst)
    token_valid && (token_class == CLS_SYM) |-> (token_length == LEN_W'(1)) && last_of_run)
    else $error("symbol token with bad length or run mark");

  a_key_len: assert property (@(posedge clk) disable iff (rst)
    token_valid && (token_class == CLS_KEY) |-> token_length == KEYWORD_LEN)
    else $error("keyword token with bad length");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> (token_length != '0) && (token_length <= LEN_W'(LEN_CAP)))
    else $error("token length out of range");

  a_accept_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (tokens.count != 2'd0) && !pop |=> token_valid)
    else $error("token lost after accepted byte");
`endif

endmodule
`default_nettype wire

// File: tb/tb_lexical_token_classifier.sv
// Self-checking testbench for lexical_token_classifier: a character stream in, tokens out.
// Depends on lxc_pkg and the classifier RTL; predicts every token with its own scanner copy.
`timescale 1ns / 1ps
module tb_lexical_token_classifier;
  import lxc_pkg::*;

  // A run with no transaction on either channel for this many cycles is a hang.
  localparam int WATCHDOG_LIMIT = 2000;
  // The classifier buffers a token when its closing byte is accepted, so a short
  // tail is enough to catch a token that should never have come.
  localparam int TAIL_CYCLES = 20;
  localparam int REPORT_MAX = 10;

  // Characters the scanner treats specially.
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;

  typedef enum {KIND_DIGIT, KIND_ALPHA, KIND_OPER, KIND_SYM, KIND_OTHER} char_kind_t;

  logic                clk;
  logic                rst;
  logic                char_valid;
  logic                char_stall;
  logic [7:0]          char_code;
  logic                token_valid;
  logic                token_stall;
  logic [2:0]          token_class;
  logic [LEN_W-1:0]    token_length;
  logic [HEAD_W-1:0]   token_head;
  logic                last_of_run;

  // Scanner state as the testbench sees it, updated at each accepted byte.
  scan_state_t         cur_state = SCAN_IDLE;
  logic [LEN_W-1:0]    cur_len = '0;
  logic [HEAD_W-1:0]   cur_head = '0;

  // Tokens that accepted bytes have closed but that have not come out yet.
  token_t              tokens_due[$];

  int                  items_sent = 0;
  int                  mismatches = 0;
  // Percent chance of an idle burst before a byte, and of a stall burst on the
  // token side. Both are zero for the full-rate part at the end.
  int                  in_pct = 0;
  int                  out_pct = 0;

  lexical_token_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_class  (token_class),
    .token_length (token_length),
    .token_head   (token_head),
    .last_of_run  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic char_kind_t classify_char(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return KIND_DIGIT;
    if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
        c == CH_UNDER) return KIND_ALPHA;
    case (c)
      CH_STAR, CH_PLUS, CH_MINUS, CH_SLASH: return KIND_OPER;
      CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_SEMI, CH_COMMA: return KIND_SYM;
      default: return KIND_OTHER;
    endcase
  endfunction

  // Adds one character to the open token. Only the first eight are kept, and
  // the length stops counting at the cap.
  task automatic append_char(input logic [7:0] c);
    if (cur_len < HEAD_CHARS) cur_head[8*cur_len +: 8] = c;
    if (cur_len < LEN_CAP) cur_len = cur_len + 1'b1;
  endtask

  task automatic open_token(input scan_state_t st, input logic [7:0] c);
    cur_state = st;
    cur_len = '0;
    cur_head = '0;
    append_char(c);
  endtask

  // Runs one accepted byte through the scanner and queues the tokens it
  // closes. A byte that ends a token is scanned again from idle, so a
  // closing symbol yields a second token right after the first.
  task automatic scan_char(input logic [7:0] c);
    char_kind_t kind;
    token_t     toks[2];
    int         n;
    logic       extend;
    kind = classify_char(c);
    n = 0;
    extend = 1'b0;
    if (cur_state != SCAN_IDLE) begin
      case (cur_state)
        SCAN_NUM:   extend = (kind == KIND_DIGIT);
        SCAN_IDENT: extend = (kind == KIND_DIGIT) || (kind == KIND_ALPHA);
        default:    extend = (kind == KIND_OPER);
      endcase
      if (extend) begin
        append_char(c);
      end else begin
        case (cur_state)
          SCAN_NUM: toks[0].cls = CLS_NUM;
          SCAN_IDENT: begin
            // Only an exact four-letter match is a keyword.
            if (cur_len == KEYWORD_LEN && (cur_head == WORD_MAIN || cur_head == WORD_VOID))
              toks[0].cls = CLS_KEY;
            else
              toks[0].cls = CLS_IDENT;
          end
          default: toks[0].cls = CLS_OPER;
        endcase
        toks[0].len = cur_len;
        toks[0].head = cur_head;
        toks[0].last = 1'b0;
        n = 1;
        cur_state = SCAN_IDLE;
        cur_len = '0;
        cur_head = '0;
      end
    end
    if (!extend) begin
      case (kind)
        KIND_DIGIT: open_token(SCAN_NUM, c);
        KIND_ALPHA: open_token(SCAN_IDENT, c);
        KIND_OPER:  open_token(SCAN_OPER, c);
        KIND_SYM: begin
          toks[n] = '{cls: CLS_SYM, len: 7'd1, head: {56'd0, c}, last: 1'b0};
          n++;
        end
        default: ;
      endcase
    end
    if (n > 0) toks[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) tokens_due.push_back(toks[i]);
  endtask

  // Sends one byte on the char channel, with an idle burst in front of it at
  // random, and returns at the edge that accepts it.
  task automatic send_char(input logic [7:0] c);
    if (in_pct > 0 && $urandom_range(0, 99) < in_pct) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    scan_char(c);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  // Token lengths are mostly short; now and then a run goes past the length
  // cap so that saturation and the truncated head are exercised.
  function automatic int token_len();
    if ($urandom_range(0, 29) == 0) return $urandom_range(60, 70);
    return $urandom_range(1, 9);
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return CH_UPPER_A + 8'(r);
    if (r < 52) return CH_LOWER_A + 8'(r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_oper();
    case ($urandom_range(0, 3))
      0: return CH_STAR;
      1: return CH_PLUS;
      2: return CH_MINUS;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] rand_sym();
    case ($urandom_range(0, 5))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      2: return CH_LPAREN;
      3: return CH_RPAREN;
      4: return CH_SEMI;
      default: return CH_COMMA;
    endcase
  endfunction

  // Emits one lexical element of source text. Neighbors of the same kind
  // merge into one longer token, which is fine: the predictor follows along.
  task automatic send_random_token();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    len = token_len();
    if (pick < 18) begin
      repeat (len) send_char(rand_digit());
    end else if (pick < 30) begin
      // Keywords and words that nearly match one.
      case ($urandom_range(0, 6))
        0: send_text("main");
        1: send_text("void");
        2: send_text("mai");
        3: send_text("maim");
        4: send_text("mainx");
        5: send_text("Void");
        default: send_text("voi_d");
      endcase
    end else if (pick < 42) begin
      send_char(rand_alpha());
      repeat (len - 1) begin
        if ($urandom_range(0, 4) == 0) send_char(rand_digit());
        else send_char(rand_alpha());
      end
    end else if (pick < 54) begin
      repeat (len) send_char(rand_oper());
    end else if (pick < 68) begin
      send_char(rand_sym());
    end else if (pick < 84) begin
      case ($urandom_range(0, 2))
        0: send_char(CH_SPACE);
        1: send_char(CH_TAB);
        default: send_char(CH_LF);
      endcase
    end else begin
      // Any byte at all, the upper half included.
      send_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic stream_tokens(input int count, input bit vary_pressure);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if (vary_pressure && $urandom_range(0, 49) == 0) begin
        in_pct = pick_pct();
        out_pct = pick_pct();
      end
      send_random_token();
    end
  endtask

  // Every character class, both keywords, every operator and symbol, a number
  // ended by a letter, an identifier ended by a symbol (two tokens from one
  // byte), non-ASCII bytes both inside a token and while idle.
  task automatic test_directed_mix();
    in_pct = 20;
    out_pct = 20;
    send_text("0 9a main;void(+-*/Z");
    // Lowest byte of the upper half: it closes the identifier and is dropped.
    send_char(8'h80);
    send_text("_{}");
    // All ones while idle: an ordinary dropped byte, not an end mark.
    send_char(8'hFF);
    send_text(",)");
  endtask

  task automatic test_random_stream(input int count);
    stream_tokens(count, 1'b1);
  endtask

  task automatic test_full_rate(input int count);
    in_pct = 0;
    out_pct = 0;
    stream_tokens(count, 1'b0);
  endtask

  // Token side stall in random bursts.
  initial begin : token_backpressure
    int hold;
    hold = 0;
    token_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        if (hold == 0) token_stall <= 1'b0;
      end else if (out_pct > 0 && $urandom_range(0, 99) < out_pct) begin
        token_stall <= 1'b1;
        hold = $urandom_range(1, 10);
      end
    end
  end

  // Each token transaction is checked against the oldest predicted token.
  always @(posedge clk) begin : token_check
    token_t due;
    if (!rst && token_valid && !token_stall) begin
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected token: class %0d length %0d head %h last %0d",
                   token_class, token_length, token_head, last_of_run);
      end else begin
        due = tokens_due.pop_front();
        if (token_class !== due.cls || token_length !== due.len ||
            token_head !== due.head || last_of_run !== due.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("token mismatch: expected class %0d length %0d head %h last %0d,",
                     due.cls, due.len, due.head, due.last);
            $display("  got class %0d length %0d head %h last %0d",
                     token_class, token_length, token_head, last_of_run);
          end
        end
      end
    end
  end

  // Ends the run if neither channel moves a transaction for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (char_valid && !char_stall) || (token_valid && !token_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    char_valid <= 1'b0;
    char_code <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_mix();
    test_random_stream(1000);
    test_full_rate(420);

    char_valid <= 1'b0;
    // A token still open here is never emitted, so only the closed ones are
    // waited for; the tail then catches anything extra.
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
